FILE: src/fdtd_pkg.sv
// shared constants, types and saturation helpers of the fdtd line
package fdtd_pkg;

   localparam int NODES      = 1024;
   localparam int ADDR_W     = $clog2(NODES);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int FIELD_W    = 32;
   localparam int COEFF_W    = 32;
   localparam int COEFF_FRAC = 20;
   localparam int DIFF_W     = FIELD_W + 1;
   localparam int PROD_W     = COEFF_W + DIFF_W;
   localparam int RND_W      = PROD_W - COEFF_FRAC;
   localparam int ENTRY_W    = 2 * FIELD_W;
   localparam int COEF_ENTRY_W = 4 * COEFF_W;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;
   localparam int BCOEF_W    = 22;
   localparam int MODE_W     = 2;

   localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
   localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
   localparam logic signed [COEFF_W-1:0] COEFF_ONE = COEFF_W'(1) <<< COEFF_FRAC;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEFF_FRAC - 1);

   localparam logic [CNT_W-1:0] SIZE_MIN   = CNT_W'(4);
   localparam logic [CNT_W-1:0] SIZE_MAX   = CNT_W'(NODES);
   localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(1024);
   localparam logic [ADDR_W-1:0] SRC_MIN   = ADDR_W'(2);
   localparam logic [ADDR_W-1:0] SRC_RESET = ADDR_W'(50);

   localparam logic [CMD_W-1:0] CMD_STEP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   localparam logic [MODE_W-1:0] BND_FIXED  = 2'd0;
   localparam logic [MODE_W-1:0] BND_SIMPLE = 2'd1;
   localparam logic [MODE_W-1:0] BND_ADVECT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUNDARY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TFSF        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_FIXED = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_LEFT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_RIGHT = 3'd6;

   typedef struct packed {
      logic                      write_h;
      logic                      tf_apply;
      logic [ADDR_W-1:0]         addr;
      logic signed [FIELD_W-1:0] keep;
   } fdtd_meta_type;

   typedef struct packed {
      logic                      valid;
      fdtd_meta_type             meta;
      logic signed [COEFF_W-1:0] self_c;
      logic signed [DIFF_W-1:0]  x;
      logic signed [COEFF_W-1:0] curl_c;
      logic signed [DIFF_W-1:0]  d;
   } fdtd_op_type;

   typedef struct packed {
      logic                      valid;
      logic                      write_h;
      logic [ADDR_W-1:0]         addr;
      logic signed [FIELD_W-1:0] e;
      logic signed [FIELD_W-1:0] h;
   } fdtd_wr_type;

   function automatic logic signed [FIELD_W-1:0] sat_rnd(input logic signed [RND_W-1:0] v);
      logic signed [RND_W-1:0] hi;
      logic signed [RND_W-1:0] lo;
      hi = RND_W'(FIELD_MAX);
      lo = RND_W'(FIELD_MIN);
      if (v > hi) return FIELD_MAX;
      if (v < lo) return FIELD_MIN;
      return v[FIELD_W-1:0];
   endfunction

   function automatic logic signed [FIELD_W-1:0] sat_sum(input logic signed [DIFF_W-1:0] v);
      logic signed [DIFF_W-1:0] hi;
      logic signed [DIFF_W-1:0] lo;
      hi = DIFF_W'(FIELD_MAX);
      lo = DIFF_W'(FIELD_MIN);
      if (v > hi) return FIELD_MAX;
      if (v < lo) return FIELD_MIN;
      return v[FIELD_W-1:0];
   endfunction

endpackage

FILE: src/fdtd_req_if.sv
// request channel: command word with node index, coefficients and source values
interface fdtd_req_if import fdtd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic [ADDR_W-1:0]         node_index;
   logic signed [COEFF_W-1:0] e_loss_coeff;
   logic signed [COEFF_W-1:0] e_curl_coeff;
   logic signed [COEFF_W-1:0] h_loss_coeff;
   logic signed [COEFF_W-1:0] h_curl_coeff;
   logic signed [FIELD_W-1:0] source_value;
   logic signed [FIELD_W-1:0] tfsf_value;

   modport source (output valid, command, node_index, e_loss_coeff, e_curl_coeff,
                   h_loss_coeff, h_curl_coeff, source_value, tfsf_value, input ready);
   modport sink (input valid, command, node_index, e_loss_coeff, e_curl_coeff,
                 h_loss_coeff, h_curl_coeff, source_value, tfsf_value, output ready);
endinterface

FILE: src/fdtd_rsp_if.sv
// response channel: e and h at the probed node
interface fdtd_rsp_if import fdtd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] e_value;
   logic signed [FIELD_W-1:0] h_value;

   modport source (output valid, e_value, h_value, input ready);
   modport sink (input valid, e_value, h_value, output ready);
endinterface

FILE: src/fdtd_ram.sv
// generic single write port, single read port ram with registered read
module fdtd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/fdtd_update.sv
// field update pipeline: sat(P(self,x) + P(curl,d)), optional tfsf subtract
module fdtd_update import fdtd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  fdtd_op_type               op_in,
   input  logic signed [FIELD_W-1:0] sub_value,
   output fdtd_wr_type               wr_out,
   output logic                      busy
);
   fdtd_op_type               a_ff;
   logic                      b_valid_ff, c_valid_ff, d_valid_ff;
   fdtd_meta_type             b_meta_ff, c_meta_ff, d_meta_ff;
   logic signed [PROD_W-1:0]  p1_ff, p2_ff;
   logic signed [FIELD_W-1:0] r1_ff, r2_ff, sum_ff;
   fdtd_wr_type               wr_ff;

   logic signed [PROD_W-1:0]  p1_in, p2_in, q1, q2, bias1, bias2;
   logic signed [RND_W-1:0]   t1, t2;
   logic signed [FIELD_W-1:0] sum_in, res_in;

   always_comb begin
      p1_in = PROD_W'(a_ff.self_c) * PROD_W'(a_ff.x);
      p2_in = PROD_W'(a_ff.curl_c) * PROD_W'(a_ff.d);
      // round half away from zero: one less bias for negative products
      bias1 = p1_ff[PROD_W-1] ? $signed(ROUND_HALF - PROD_W'(1)) : $signed(ROUND_HALF);
      bias2 = p2_ff[PROD_W-1] ? $signed(ROUND_HALF - PROD_W'(1)) : $signed(ROUND_HALF);
      q1 = p1_ff + bias1;
      q2 = p2_ff + bias2;
      t1 = q1[PROD_W-1:COEFF_FRAC];
      t2 = q2[PROD_W-1:COEFF_FRAC];
      sum_in = sat_sum(DIFF_W'(r1_ff) + DIFF_W'(r2_ff));
      res_in = d_meta_ff.tf_apply ? sat_sum(DIFF_W'(sum_ff) - DIFF_W'(sub_value)) : sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         wr_ff.valid <= 1'b0;
      end else begin
         a_ff.valid <= op_in.valid;
         b_valid_ff <= a_ff.valid;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         wr_ff.valid <= d_valid_ff;
      end
      a_ff.meta   <= op_in.meta;
      a_ff.self_c <= op_in.self_c;
      a_ff.x      <= op_in.x;
      a_ff.curl_c <= op_in.curl_c;
      a_ff.d      <= op_in.d;
      b_meta_ff <= a_ff.meta;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      c_meta_ff <= b_meta_ff;
      r1_ff <= sat_rnd(t1);
      r2_ff <= sat_rnd(t2);
      d_meta_ff <= c_meta_ff;
      sum_ff <= sum_in;
      wr_ff.write_h <= d_meta_ff.write_h;
      wr_ff.addr <= d_meta_ff.addr;
      wr_ff.e <= d_meta_ff.write_h ? d_meta_ff.keep : res_in;
      wr_ff.h <= d_meta_ff.write_h ? res_in : d_meta_ff.keep;
   end

   assign wr_out = wr_ff;
   assign busy = a_ff.valid | b_valid_ff | c_valid_ff | d_valid_ff | wr_ff.valid;
endmodule

FILE: src/fdtd_1d_field_update.sv
// top level of the fixed point 1d fdtd line: sequencer, field and coefficient rams
//
// req_ch carries one command word: step, load coefficients of a node, or read a node.
// rsp_ch returns one word per command: e and h at node_index after the command.
// csr_* writes the line configuration; write it only while the block is idle.
// after reset the field ram is swept to zero, one entry per cycle, while req_ch.ready
// stays low; csr writes are taken during that time.
// a step makes two passes over the field ram, one read per node per cycle:
// h pass over size nodes, e pass over size or size-1 nodes, each followed by a
// drain of the 5-stage update pipeline and a boundary fix-up; the e pass is also
// followed by the source fix-up and a further drain.
// one command is worked on at a time; the field ram port sets the step time.
// the response sits in an output register; a new command is taken while it
// waits, and a further finished result waits in a holding register until the
// receiver takes the first one.
module fdtd_1d_field_update import fdtd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   fdtd_req_if.sink              req_ch,
   fdtd_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   typedef enum logic [13:0] {
      ST_CLEAR  = 14'b00000000000001,
      ST_IDLE   = 14'b00000000000010,
      ST_HSWEEP = 14'b00000000000100,
      ST_HDRAIN = 14'b00000000001000,
      ST_HBOUND = 14'b00000000010000,
      ST_BDRAIN = 14'b00000000100000,
      ST_ESWEEP = 14'b00000001000000,
      ST_EDRAIN = 14'b00000010000000,
      ST_EBOUND = 14'b00000100000000,
      ST_SOURCE = 14'b00001000000000,
      ST_FDRAIN = 14'b00010000000000,
      ST_FETCH  = 14'b00100000000000,
      ST_CATCH  = 14'b01000000000000,
      ST_EMIT   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [CNT_W-1:0]          size_cfg_ff;
   logic [ADDR_W-1:0]         src_cfg_ff;
   logic [MODE_W-1:0]         mode_ff;
   logic                      tfsf_ff, rfix_ff;
   logic signed [BCOEF_W-1:0] cl_ff, cr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_cfg_ff <= SIZE_RESET;
         src_cfg_ff  <= SRC_RESET;
         mode_ff     <= BND_FIXED;
         tfsf_ff     <= 1'b0;
         rfix_ff     <= 1'b0;
         cl_ff       <= '0;
         cr_ff       <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SIZE:        size_cfg_ff <= csr_data[CNT_W-1:0];
            CSR_SOURCE:      src_cfg_ff  <= csr_data[ADDR_W-1:0];
            CSR_BOUNDARY:    mode_ff     <= csr_data[MODE_W-1:0];
            CSR_TFSF:        tfsf_ff     <= csr_data[0];
            CSR_RIGHT_FIXED: rfix_ff     <= csr_data[0];
            CSR_COEFF_LEFT:  cl_ff       <= csr_data;
            CSR_COEFF_RIGHT: cr_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   // command registers
   logic [ADDR_W-1:0]         cnt_ff, cnt_in;
   logic [ADDR_W-1:0]         node_ff, s_ff, size_m1_ff, size_m2_ff, e_last_ff;
   logic signed [FIELD_W-1:0] src_val_ff, tf_val_ff;

   // sweep and capture registers
   logic                      rd_valid_ff, rd_h_ff;
   logic [ADDR_W-1:0]         rd_addr_ff;
   logic signed [FIELD_W-1:0] prev_e_ff, prev_h_ff;
   logic signed [COEFF_W-1:0] prev_hs_ff, prev_hc_ff;
   logic signed [FIELD_W-1:0] saved_e_ff, saved_h_ff, last_e_ff, last_h_ff;
   logic signed [FIELD_W-1:0] hnew_ff, e1new_ff, e0_ff, h0_ff, es_e_ff, es_h_ff;
   logic signed [FIELD_W-1:0] hold_e_ff, hold_h_ff;
   logic                      rsp_valid_ff;
   logic signed [FIELD_W-1:0] rsp_e_ff, rsp_h_ff;

   // ram ports
   logic                      fld_wr_en, fld_rd_en;
   logic [ADDR_W-1:0]         fld_wr_addr, fld_rd_addr;
   logic [ENTRY_W-1:0]        fld_wr_data, fld_rd_data;
   logic [COEF_ENTRY_W-1:0]   coef_wr_data, coef_rd_data;
   logic                      coef_wr_en;

   fdtd_op_type op;
   fdtd_wr_type wr;
   logic        unit_busy;

   logic signed [FIELD_W-1:0] fe, fh;
   logic signed [COEFF_W-1:0] c_es, c_ec, c_hs, c_hc;
   logic                      accept, sweep_rd, drained, out_free, bnd_on, advect;
   logic [CNT_W-1:0]          size_c, size_c_m2, src_c;

   assign fe   = fld_rd_data[ENTRY_W-1:FIELD_W];
   assign fh   = fld_rd_data[FIELD_W-1:0];
   assign c_es = coef_rd_data[4*COEFF_W-1:3*COEFF_W];
   assign c_ec = coef_rd_data[3*COEFF_W-1:2*COEFF_W];
   assign c_hs = coef_rd_data[2*COEFF_W-1:COEFF_W];
   assign c_hc = coef_rd_data[COEFF_W-1:0];

   assign accept   = req_ch.valid && req_ch.ready;
   assign drained  = !rd_valid_ff && !unit_busy && !op.valid;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign advect   = (mode_ff == BND_ADVECT);
   assign bnd_on   = (mode_ff == BND_SIMPLE) || advect;
   assign sweep_rd = (state_ff == ST_HSWEEP) || (state_ff == ST_ESWEEP);

   always_comb begin
      size_c = size_cfg_ff;
      if (size_cfg_ff < SIZE_MIN) size_c = SIZE_MIN;
      if (size_cfg_ff > SIZE_MAX) size_c = SIZE_MAX;
      size_c_m2 = size_c - CNT_W'(2);
      src_c = CNT_W'(src_cfg_ff);
      if (src_cfg_ff < SRC_MIN) src_c = CNT_W'(SRC_MIN);
      if (src_c > size_c_m2) src_c = size_c_m2;
   end

   // update operation: from swept data, else boundary and source fix-ups
   always_comb begin
      op = '0;
      if (rd_valid_ff && rd_h_ff) begin
         op.valid         = (rd_addr_ff != '0);
         op.meta.write_h  = 1'b1;
         op.meta.tf_apply = tfsf_ff && (rd_addr_ff == s_ff);
         op.meta.addr     = rd_addr_ff - ADDR_W'(1);
         op.meta.keep     = prev_e_ff;
         op.self_c        = prev_hs_ff;
         op.x             = DIFF_W'(prev_h_ff);
         op.curl_c        = prev_hc_ff;
         op.d             = DIFF_W'(fe) - DIFF_W'(prev_e_ff);
      end else if (rd_valid_ff) begin
         op.valid     = (rd_addr_ff != '0);
         op.meta.addr = rd_addr_ff;
         op.meta.keep = fh;
         op.self_c    = c_es;
         op.x         = DIFF_W'(fe);
         op.curl_c    = c_ec;
         op.d         = DIFF_W'(fh) - DIFF_W'(prev_h_ff);
      end else if (state_ff == ST_HBOUND) begin
         op.valid        = bnd_on;
         op.meta.write_h = 1'b1;
         op.meta.addr    = size_m1_ff;
         op.meta.keep    = last_e_ff;
         op.self_c       = COEFF_ONE;
         op.x            = DIFF_W'(saved_h_ff);
         op.curl_c       = advect ? COEFF_W'(cr_ff) : '0;
         op.d            = DIFF_W'(hnew_ff) - DIFF_W'(last_h_ff);
      end else if (state_ff == ST_EBOUND) begin
         op.valid     = bnd_on;
         op.meta.addr = '0;
         op.meta.keep = h0_ff;
         op.self_c    = COEFF_ONE;
         op.x         = DIFF_W'(saved_e_ff);
         op.curl_c    = advect ? COEFF_W'(cl_ff) : '0;
         op.d         = DIFF_W'(e1new_ff) - DIFF_W'(e0_ff);
      end else if (state_ff == ST_SOURCE) begin
         op.valid     = 1'b1;
         op.meta.addr = s_ff;
         op.meta.keep = es_h_ff;
         op.self_c    = COEFF_ONE;
         op.x         = DIFF_W'(es_e_ff);
         op.curl_c    = COEFF_ONE;
         op.d         = DIFF_W'(src_val_ff);
      end
   end

   fdtd_update u_update (
      .clock     (clock),
      .reset     (reset),
      .op_in     (op),
      .sub_value (tf_val_ff),
      .wr_out    (wr),
      .busy      (unit_busy)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(NODES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) state_in = (req_ch.command == CMD_STEP) ? ST_HSWEEP : ST_FETCH;
         end
         ST_HSWEEP: begin
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == size_m1_ff) state_in = ST_HDRAIN;
         end
         ST_HDRAIN: if (drained) state_in = ST_HBOUND;
         ST_HBOUND: state_in = ST_BDRAIN;
         ST_BDRAIN: begin
            cnt_in = '0;
            if (drained) state_in = ST_ESWEEP;
         end
         ST_ESWEEP: begin
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == e_last_ff) state_in = ST_EDRAIN;
         end
         ST_EDRAIN: if (drained) state_in = ST_EBOUND;
         ST_EBOUND: state_in = ST_SOURCE;
         ST_SOURCE: state_in = ST_FDRAIN;
         ST_FDRAIN: if (drained) state_in = ST_FETCH;
         ST_FETCH:  state_in = ST_CATCH;
         ST_CATCH:  state_in = ST_EMIT;
         ST_EMIT:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         rd_valid_ff <= sweep_rd;
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_h_ff    <= (state_ff == ST_HSWEEP);
      rd_addr_ff <= cnt_ff;
      if (accept) begin
         node_ff    <= req_ch.node_index;
         src_val_ff <= req_ch.source_value;
         tf_val_ff  <= req_ch.tfsf_value;
         s_ff       <= src_c[ADDR_W-1:0];
         size_m1_ff <= ADDR_W'(size_c - CNT_W'(1));
         size_m2_ff <= size_c_m2[ADDR_W-1:0];
         e_last_ff  <= rfix_ff ? size_c_m2[ADDR_W-1:0] : ADDR_W'(size_c - CNT_W'(1));
      end
      if (rd_valid_ff && rd_h_ff) begin
         prev_e_ff  <= fe;
         prev_h_ff  <= fh;
         prev_hs_ff <= c_hs;
         prev_hc_ff <= c_hc;
         if (rd_addr_ff == ADDR_W'(1)) saved_e_ff <= fe;
         if (rd_addr_ff == size_m2_ff) saved_h_ff <= fh;
         if (rd_addr_ff == size_m1_ff) begin
            last_e_ff <= fe;
            last_h_ff <= fh;
         end
      end else if (rd_valid_ff) begin
         prev_h_ff <= fh;
         if (rd_addr_ff == '0) begin
            e0_ff <= fe;
            h0_ff <= fh;
         end
      end
      // new values needed by the boundary and source fix-ups
      if (wr.valid && wr.write_h && wr.addr == size_m2_ff) hnew_ff <= wr.h;
      if (wr.valid && !wr.write_h && wr.addr == ADDR_W'(1)) e1new_ff <= wr.e;
      if (wr.valid && !wr.write_h && wr.addr == s_ff) begin
         es_e_ff <= wr.e;
         es_h_ff <= wr.h;
      end
      if (state_ff == ST_CATCH) begin
         hold_e_ff <= fe;
         hold_h_ff <= fh;
      end
      if (state_ff == ST_EMIT && out_free) begin
         rsp_e_ff <= hold_e_ff;
         rsp_h_ff <= hold_h_ff;
      end
   end

   assign fld_wr_en   = (state_ff == ST_CLEAR) || wr.valid;
   assign fld_wr_addr = (state_ff == ST_CLEAR) ? cnt_ff : wr.addr;
   assign fld_wr_data = (state_ff == ST_CLEAR) ? '0 : {wr.e, wr.h};
   assign fld_rd_en   = sweep_rd || (state_ff == ST_FETCH);
   assign fld_rd_addr = (state_ff == ST_FETCH) ? node_ff : cnt_ff;

   assign coef_wr_en   = accept && (req_ch.command == CMD_LOAD);
   assign coef_wr_data = {req_ch.e_loss_coeff, req_ch.e_curl_coeff,
                          req_ch.h_loss_coeff, req_ch.h_curl_coeff};

   fdtd_ram #(.WIDTH(ENTRY_W), .DEPTH(NODES)) u_field_ram (
      .clock   (clock),
      .wr_en   (fld_wr_en),
      .wr_addr (fld_wr_addr),
      .wr_data (fld_wr_data),
      .rd_en   (fld_rd_en),
      .rd_addr (fld_rd_addr),
      .rd_data (fld_rd_data)
   );

   fdtd_ram #(.WIDTH(COEF_ENTRY_W), .DEPTH(NODES)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (req_ch.node_index),
      .wr_data (coef_wr_data),
      .rd_en   (sweep_rd),
      .rd_addr (cnt_ff),
      .rd_data (coef_rd_data)
   );

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.e_value = rsp_e_ff;
   assign rsp_ch.h_value = rsp_h_ff;
endmodule
